>>> rtl/scc_pkg.sv
// Shared types and codes for the semispace copying collector.
package scc_pkg;

	localparam int HEAP_CELLS_DEF = 256;
	localparam int ROOT_SLOTS_DEF = 256;

	localparam logic [2:0] ACT_ALLOC   = 3'd0;
	localparam logic [2:0] ACT_READ    = 3'd1;
	localparam logic [2:0] ACT_WRITE   = 3'd2;
	localparam logic [2:0] ACT_SET     = 3'd3;
	localparam logic [2:0] ACT_DROP    = 3'd4;
	localparam logic [2:0] ACT_RROOT   = 3'd5;
	localparam logic [2:0] ACT_COLLECT = 3'd6;

	localparam logic [3:0] TAG_PAIR    = 4'd8;
	localparam logic [3:0] TAG_CLOSURE = 4'd9;
	localparam logic [3:0] TAG_FORWARD = 4'd10;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_OOM    = 2'd1;
	localparam logic [1:0] STS_BADTAG = 2'd2;

	typedef struct packed {
		logic [3:0]  tag;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
	} cell_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [8:0]  cell_address;
		logic [7:0]  root_slot;
		logic [3:0]  object_tag;
		logic [31:0] data_word0;
		logic [31:0] data_word1;
		logic [31:0] data_word2;
	} req_t;

	typedef struct packed {
		logic [8:0]  result_address;
		logic [3:0]  result_tag;
		logic [31:0] result_word0;
		logic [31:0] result_word1;
		logic [31:0] result_word2;
		logic [8:0]  cells_in_use;
		logic [1:0]  status;
	} rsp_t;

endpackage

>>> rtl/semispace_copying_collector_core.sv
// Top level of the semispace copying collector: sequencer, root table and result register.
//
// This block keeps a heap of tagged cells in two halves and serves one transaction at a time:
// allocate, read or write a cell, set, drop or read a root slot, and collect. After reset it
// first clears the whole heap of 2*HEAP_CELLS cells (512 by default), one cell a cycle;
// req_stall stays high meanwhile. A write, set or drop, and an allocation that still fits,
// pass through the execute and result states before a result waits. A cell or root read adds
// a read-data state, since the heap and root memories have a registered read. A collection,
// whether asked for or started by a full allocation, steps through the root table one empty
// slot a cycle and then scans the copied cells. Each live root or scanned cell passes through
// a read state, a data state, a forward state and a write-back state. A pair or closure adds a
// word state per word; a from-space pointer adds a read-data state and, per cell copied, a
// forward state, since each pointer is resolved by one heap read and a copy needs two heap
// writes. The result is held in an output register; a new request is accepted while it waits.
module semispace_copying_collector_core
	import scc_pkg::*;
#(
	parameter int HEAP_CELLS = HEAP_CELLS_DEF,
	parameter int ROOT_SLOTS = ROOT_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW  = $clog2(2 * HEAP_CELLS);
	localparam int HW  = $clog2(HEAP_CELLS);
	localparam int RW  = (ROOT_SLOTS > 1) ? $clog2(ROOT_SLOTS) : 1;
	localparam int RCW = $clog2(ROOT_SLOTS + 1);
	localparam logic [31:0]   H32       = 32'(HEAP_CELLS);
	localparam logic [31:0]   H2_32     = 32'(2 * HEAP_CELLS);
	localparam logic [HW-1:0] FREE_LAST = HW'(HEAP_CELLS - 1);
	localparam logic [AW-1:0] CLR_LAST  = AW'(2 * HEAP_CELLS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_RD_CELL, ST_RD_ROOT,
		ST_GC_ROOT, ST_GC_ROOT_DATA, ST_GC_SCAN, ST_GC_SCAN_DATA,
		ST_FWD, ST_WORD, ST_WORD_DATA, ST_WORD_FWD, ST_WB, ST_DONE
	} state_t;

	state_t          state_q;
	req_t            req_q;
	logic [AW-1:0]   clr_q;
	logic            upper_q;
	logic [HW-1:0]   free_q;
	logic [HW-1:0]   scan_q;
	logic [RCW-1:0]  ridx_q;
	logic [ROOT_SLOTS-1:0] valid_q;
	logic            retry_q;
	logic            rvalid_q;
	logic [1:0]      gst_q;
	cell_t           work_q;
	logic [1:0]      kidx_q;
	logic            wb_heap_q;
	logic            wb_en_q;
	logic [AW-1:0]   cur_q;
	logic [AW-1:0]   copy_addr_q;
	logic [AW-1:0]   res_addr_q;
	cell_t           res_cell_q;
	logic [1:0]      res_st_q;

	logic          heap_we, heap_re;
	logic [AW-1:0] heap_waddr, heap_raddr;
	cell_t         heap_wdata, heap_rd;

	cell_t         root_mem [ROOT_SLOTS];
	cell_t         root_rd;
	logic          root_we, root_re;
	logic [RW-1:0] root_waddr, root_raddr;
	cell_t         root_wdata;

	logic          addr_ok, slot_ok;
	logic [AW-1:0] cell_idx;
	logic [RW-1:0] slot_idx;
	logic [RW-1:0] ridx;
	logic [31:0]   wsel;
	logic          wsel_from;
	logic [1:0]    klast;

	function automatic logic [AW-1:0] to_addr(input logic up, input logic [HW-1:0] f);
		to_addr = (up ? AW'(HEAP_CELLS) : AW'(0)) + AW'(f);
	endfunction

	assign addr_ok  = (32'(req_q.cell_address) < H2_32);
	assign slot_ok  = (32'(req_q.root_slot) < 32'(ROOT_SLOTS));
	assign cell_idx = AW'(req_q.cell_address);
	assign slot_idx = RW'(req_q.root_slot);
	assign ridx     = ridx_q[RW-1:0];
	assign klast    = (work_q.tag == TAG_CLOSURE) ? 2'd2 : 2'd1;

	always_comb begin
		unique case (kidx_q)
			2'd0:    wsel = work_q.w0;
			2'd1:    wsel = work_q.w1;
			default: wsel = work_q.w2;
		endcase
	end

	// A word points into from-space when it is an absolute index inside the other half.
	assign wsel_from = upper_q ? (wsel < H32) : ((wsel >= H32) && (wsel < H2_32));

	assign req_stall = (state_q != ST_IDLE);

	// Memory port control follows the sequencer state.
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = cur_q;
		heap_wdata = work_q;
		heap_re    = 1'b0;
		heap_raddr = cell_idx;
		root_we    = 1'b0;
		root_waddr = ridx;
		root_wdata = work_q;
		root_re    = 1'b0;
		root_raddr = ridx;
		unique case (state_q)
			ST_CLEAR: begin
				heap_we    = 1'b1;
				heap_waddr = clr_q;
				heap_wdata = '0;
			end
			ST_EXEC: begin
				if (req_q.action == ACT_WRITE && addr_ok) begin
					heap_we    = 1'b1;
					heap_waddr = cell_idx;
					heap_wdata = '{tag: req_q.object_tag, w0: req_q.data_word0,
						w1: req_q.data_word1, w2: req_q.data_word2};
				end
				if (req_q.action == ACT_READ && addr_ok) begin
					heap_re = 1'b1;
				end
				if (req_q.action == ACT_SET && slot_ok) begin
					root_we    = 1'b1;
					root_waddr = slot_idx;
					root_wdata = '{tag: req_q.object_tag, w0: req_q.data_word0,
						w1: req_q.data_word1, w2: req_q.data_word2};
				end
				if (req_q.action == ACT_RROOT && slot_ok) begin
					root_re    = 1'b1;
					root_raddr = slot_idx;
				end
			end
			ST_GC_ROOT: begin
				if (ridx_q != RCW'(ROOT_SLOTS) && valid_q[ridx]) begin
					root_re = 1'b1;
				end
			end
			ST_GC_SCAN: begin
				if (scan_q < free_q) begin
					heap_re    = 1'b1;
					heap_raddr = to_addr(upper_q, scan_q);
				end
			end
			ST_WORD: begin
				if (wsel_from) begin
					heap_re    = 1'b1;
					heap_raddr = AW'(wsel);
				end
			end
			ST_WORD_DATA: begin
				if (heap_rd.tag != TAG_FORWARD && free_q < FREE_LAST) begin
					heap_we    = 1'b1;
					heap_waddr = to_addr(upper_q, free_q);
					heap_wdata = heap_rd;
				end
			end
			ST_WORD_FWD: begin
				// The old cell keeps its second and third words; only tag and first word change.
				heap_we    = 1'b1;
				heap_waddr = AW'(wsel);
				heap_wdata = '{tag: TAG_FORWARD, w0: 32'(copy_addr_q),
					w1: heap_rd.w1, w2: heap_rd.w2};
			end
			ST_WB: begin
				if (wb_en_q) begin
					heap_we = wb_heap_q;
					root_we = !wb_heap_q;
				end
			end
			default: begin
			end
		endcase
	end

	scc_heap #(
		.DEPTH (2 * HEAP_CELLS),
		.AW    (AW)
	) u_heap (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.re    (heap_re),
		.raddr (heap_raddr),
		.rdata (heap_rd)
	);

	// Root table storage; entries are only meaningful once their valid bit is set.
	always_ff @(posedge clk) begin
		if (root_we) begin
			root_mem[root_waddr] <= root_wdata;
		end
		if (root_re) begin
			root_rd <= root_mem[root_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			req_q       <= '0;
			clr_q       <= '0;
			upper_q     <= 1'b0;
			free_q      <= '0;
			scan_q      <= '0;
			ridx_q      <= '0;
			valid_q     <= '0;
			retry_q     <= 1'b0;
			rvalid_q    <= 1'b0;
			gst_q       <= STS_OK;
			work_q      <= '0;
			kidx_q      <= '0;
			wb_heap_q   <= 1'b0;
			wb_en_q     <= 1'b0;
			cur_q       <= '0;
			copy_addr_q <= '0;
			res_addr_q  <= '0;
			res_cell_q  <= '0;
			res_st_q    <= STS_OK;
			rsp_valid   <= 1'b0;
			rsp         <= '0;
		end else begin
			// The result state sets rsp_valid itself; elsewhere a taken result clears it.
			if (rsp_valid && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_addr_q <= '0;
					res_cell_q <= '0;
					res_st_q   <= STS_OK;
					state_q    <= ST_DONE;
					case (req_q.action)
						ACT_ALLOC: begin
							if (free_q < FREE_LAST) begin
								res_addr_q <= to_addr(upper_q, free_q);
								free_q     <= free_q + 1'b1;
							end else begin
								retry_q <= 1'b1;
								upper_q <= ~upper_q;
								free_q  <= '0;
								scan_q  <= '0;
								ridx_q  <= '0;
								gst_q   <= STS_OK;
								state_q <= ST_GC_ROOT;
							end
						end
						ACT_READ: begin
							if (addr_ok) begin
								state_q <= ST_RD_CELL;
							end
						end
						ACT_SET: begin
							if (slot_ok) begin
								valid_q[slot_idx] <= 1'b1;
							end
						end
						ACT_DROP: begin
							if (slot_ok) begin
								valid_q[slot_idx] <= 1'b0;
							end
						end
						ACT_RROOT: begin
							rvalid_q <= slot_ok && valid_q[slot_idx];
							state_q  <= ST_RD_ROOT;
						end
						ACT_COLLECT: begin
							retry_q <= 1'b0;
							upper_q <= ~upper_q;
							free_q  <= '0;
							scan_q  <= '0;
							ridx_q  <= '0;
							gst_q   <= STS_OK;
							state_q <= ST_GC_ROOT;
						end
						default: begin
						end
					endcase
				end
				ST_RD_CELL: begin
					res_cell_q <= heap_rd;
					state_q    <= ST_DONE;
				end
				ST_RD_ROOT: begin
					if (rvalid_q) begin
						res_cell_q <= root_rd;
					end
					state_q <= ST_DONE;
				end
				ST_GC_ROOT: begin
					if (ridx_q == RCW'(ROOT_SLOTS)) begin
						state_q <= ST_GC_SCAN;
					end else if (valid_q[ridx]) begin
						state_q <= ST_GC_ROOT_DATA;
					end else begin
						ridx_q <= ridx_q + 1'b1;
					end
				end
				ST_GC_ROOT_DATA: begin
					work_q    <= root_rd;
					wb_heap_q <= 1'b0;
					state_q   <= ST_FWD;
				end
				ST_GC_SCAN: begin
					if (scan_q < free_q) begin
						cur_q   <= to_addr(upper_q, scan_q);
						state_q <= ST_GC_SCAN_DATA;
					end else begin
						// Collection is over; an allocation that triggered it retries once.
						res_st_q <= gst_q;
						state_q  <= ST_DONE;
						if (retry_q) begin
							if (free_q < FREE_LAST) begin
								res_addr_q <= to_addr(upper_q, free_q);
								free_q     <= free_q + 1'b1;
							end else begin
								res_st_q <= STS_OOM;
							end
						end
					end
				end
				ST_GC_SCAN_DATA: begin
					work_q    <= heap_rd;
					wb_heap_q <= 1'b1;
					state_q   <= ST_FWD;
				end
				ST_FWD: begin
					kidx_q <= '0;
					if (work_q.tag == TAG_PAIR || work_q.tag == TAG_CLOSURE) begin
						wb_en_q <= 1'b1;
						state_q <= ST_WORD;
					end else begin
						wb_en_q <= 1'b0;
						if (work_q.tag >= TAG_FORWARD && gst_q == STS_OK) begin
							gst_q <= STS_BADTAG;
						end
						state_q <= ST_WB;
					end
				end
				ST_WORD: begin
					if (wsel_from) begin
						state_q <= ST_WORD_DATA;
					end else begin
						kidx_q  <= kidx_q + 1'b1;
						state_q <= (kidx_q == klast) ? ST_WB : ST_WORD;
					end
				end
				ST_WORD_DATA: begin
					if (heap_rd.tag == TAG_FORWARD) begin
						unique case (kidx_q)
							2'd0:    work_q.w0 <= heap_rd.w0;
							2'd1:    work_q.w1 <= heap_rd.w0;
							default: work_q.w2 <= heap_rd.w0;
						endcase
						kidx_q  <= kidx_q + 1'b1;
						state_q <= (kidx_q == klast) ? ST_WB : ST_WORD;
					end else if (free_q >= FREE_LAST) begin
						if (gst_q == STS_OK) begin
							gst_q <= STS_OOM;
						end
						kidx_q  <= kidx_q + 1'b1;
						state_q <= (kidx_q == klast) ? ST_WB : ST_WORD;
					end else begin
						copy_addr_q <= to_addr(upper_q, free_q);
						free_q      <= free_q + 1'b1;
						state_q     <= ST_WORD_FWD;
					end
				end
				ST_WORD_FWD: begin
					unique case (kidx_q)
						2'd0:    work_q.w0 <= 32'(copy_addr_q);
						2'd1:    work_q.w1 <= 32'(copy_addr_q);
						default: work_q.w2 <= 32'(copy_addr_q);
					endcase
					kidx_q  <= kidx_q + 1'b1;
					state_q <= (kidx_q == klast) ? ST_WB : ST_WORD;
				end
				ST_WB: begin
					if (wb_heap_q) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_GC_SCAN;
					end else begin
						ridx_q  <= ridx_q + 1'b1;
						state_q <= ST_GC_ROOT;
					end
				end
				ST_DONE: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid <= 1'b1;
						rsp       <= '{result_address: 9'(res_addr_q),
							result_tag: res_cell_q.tag,
							result_word0: res_cell_q.w0,
							result_word1: res_cell_q.w1,
							result_word2: res_cell_q.w2,
							cells_in_use: 9'(free_q),
							status: res_st_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/scc_heap.sv
// Heap cell memory with one write port and one registered read port.
module scc_heap
	import scc_pkg::*;
#(
	parameter int DEPTH = 2 * HEAP_CELLS_DEF,
	parameter int AW    = $clog2(2 * HEAP_CELLS_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cell_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output cell_t         rdata
);

	cell_t mem [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
